// File: rtl/ket_pkg.sv
// Package with the shared constants and codes of the keyed entry table.
package ket_pkg;

   localparam int ENTRIES_DEFAULT    = 64;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int MODE_W      = 2;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY  = 2'd3;

endpackage

// File: rtl/keyed_entry_table_core.sv
// Top level of the keyed entry table: a slot memory searched linearly per operation.
//
//   Channel   Direction   tdata fields (lowest bit up)
//   req       in          mode[1:0], key[33:2], value[65:34], zero pad to 72 bits
//   rsp       out         status[1:0], value_out[33:2], replaced[34], zero pad to 40 bits
//
// A find, add or remove runs from acceptance through the scan, which reads one slot per cycle
// through the single memory read port, then the drain and commit states, to the result word.
// A zero key or the unused mode goes straight to the done state without a scan.
// After reset a clearing pass writes every slot to zero with req_tready low. A result
// word waiting on rsp_tready holds the block before its next acceptance only once the
// following result is ready to be shown.
module keyed_entry_table_core #(
   parameter int ENTRIES    = ket_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = ket_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = ket_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: mode, key, value, zero pad.
   input  logic [ket_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: status, value_out, replaced, zero pad.
   output logic [ket_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int EW = KEY_BITS + VALUE_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [EW-1:0] slot_mem [ENTRIES];
   logic [EW-1:0] rd_data_ff;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] ad_ff, ad_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff;
   logic          hit_ff, hit_in;
   logic          free_ff, free_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;

   logic [ket_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic [VALUE_BITS-1:0]      val_ff, val_in;

   logic [ket_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ket_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                         res_repl_ff, res_repl_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ket_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ket_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                         rsp_repl_ff, rsp_repl_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic                  req_accept;
   logic [KEY_BITS-1:0]   req_key;
   logic [VALUE_BITS-1:0] req_val;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  key_hit;
   logic                  key_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_key    = KEY_BITS'(req_tdata[33:2]);
   assign req_val    = VALUE_BITS'(req_tdata[65:34]);

   assign rd_key   = rd_data_ff[EW-1:VALUE_BITS];
   assign rd_val   = rd_data_ff[VALUE_BITS-1:0];
   assign key_hit  = rd_valid_ff && (rd_key == key_ff);
   assign key_free = rd_valid_ff && (rd_key == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_repl_ff, rsp_value_ff, rsp_status_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[ad_ff];
   end

   always_comb begin
      state_in      = state_ff;
      ad_in         = ad_ff;
      rd_valid_in   = (state_ff == S_SCAN);
      hit_in        = hit_ff | key_hit;
      free_in       = free_ff | key_free;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      hit_val_in    = hit_val_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_repl_in   = res_repl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_repl_in   = rsp_repl_ff;
      wr_en         = 1'b0;
      wr_addr       = ad_ff;
      wr_data       = '0;

      if (key_hit && !hit_ff) begin
         hit_idx_in = rd_idx_ff;
         hit_val_in = rd_val;
      end
      if (key_free && !free_ff) begin
         free_idx_in = rd_idx_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            ad_in = ad_ff + 1'b1;
            if (ad_ff == LAST_IDX) begin
               ad_in    = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               mode_in       = req_tdata[1:0];
               key_in        = req_key;
               val_in        = req_val;
               res_status_in = ket_pkg::STATUS_OK;
               res_value_in  = '0;
               res_repl_in   = 1'b0;
               ad_in         = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               if (req_tdata[1:0] == ket_pkg::MODE_UNUSED) begin
                  state_in = S_DONE;
               end else if (req_key == '0) begin
                  res_status_in = ket_pkg::STATUS_ZERO_KEY;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ad_in = ad_ff + 1'b1;
            if (ad_ff == LAST_IDX) begin
               ad_in    = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_DONE;
            case (mode_ff)
               ket_pkg::MODE_FIND: begin
                  if (hit_ff) begin
                     res_value_in = ket_pkg::VALUE_W'(hit_val_ff);
                  end else begin
                     res_status_in = ket_pkg::STATUS_NOT_FOUND;
                  end
               end
               ket_pkg::MODE_ADD: begin
                  wr_data = {key_ff, val_ff};
                  if (hit_ff) begin
                     wr_en        = 1'b1;
                     wr_addr      = hit_idx_ff;
                     res_value_in = ket_pkg::VALUE_W'(val_ff);
                     res_repl_in  = 1'b1;
                  end else if (free_ff) begin
                     wr_en        = 1'b1;
                     wr_addr      = free_idx_ff;
                     res_value_in = ket_pkg::VALUE_W'(val_ff);
                  end else begin
                     res_status_in = ket_pkg::STATUS_FULL;
                  end
               end
               ket_pkg::MODE_REMOVE: begin
                  wr_en   = hit_ff;
                  wr_addr = hit_idx_ff;
               end
               default: begin
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_repl_in   = res_repl_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ad_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ad_ff        <= ad_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= ad_ff;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      hit_val_ff    <= hit_val_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_repl_ff   <= res_repl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_repl_ff   <= rsp_repl_in;
   end

endmodule
